[sv/i2cts_pkg.sv]
// Shared types and codes for the I2C transfer sequencer.
package i2cts_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ADDR = 3'd1,
    PH_ACK  = 3'd2,
    PH_DATA = 3'd3,
    PH_STOP = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_PENDING = 3'd0,
    ST_MOVED   = 3'd1,
    ST_DONE    = 3'd2,
    ST_IOERR   = 3'd3,
    ST_STOPRX  = 3'd4,
    ST_INVALID = 3'd5
  } status_t;

  localparam logic ROLE_MASTER = 1'b0;
  localparam logic ROLE_SLAVE  = 1'b1;

  localparam logic CFG_ROLE   = 1'b0;
  localparam logic CFG_TARGET = 1'b1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef struct packed {
    logic        command;
    logic        bus_busy;
    logic        start_sent;
    logic        addr_matched;
    logic        ack_error;
    logic        tx_empty;
    logic        rx_full;
    logic        byte_finished;
    logic        stop_seen;
    logic [7:0]  data_in;
    logic [7:0]  tx_byte;
    logic [15:0] remaining;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic       issue_start;
    logic       issue_stop;
    logic       write_valid;
    logic [7:0] data_out;
    logic       ack_on;
    logic       ack_off;
    logic       clear_ack_error;
    logic       clear_stop_flag;
    logic       read_valid;
    logic [7:0] read_byte;
  } result_t;

endpackage

[sv/i2c_transfer_sequencer.sv]
// Top level of the I2C transfer sequencer: config registers and stage wiring.
//
//  channel | direction | handshake        | word
//  in_     | input     | in_valid/stall   | one status poll with command and bytes
//  out_    | output    | out_valid/stall  | status and control actions for one poll
//  cfg_    | input     | cfg_valid/ready  | register index and data
//
// A poll passes from acceptance to result through the input register, then
// decision logic on the phase register into the result register.
// One word per cycle sustained; in_stall rises only when both stages are full
// and out_stall is high. Synchronous reset clears both stages, phase (idle),
// role (master) and target address (zero). cfg_ready is always high.
module i2c_transfer_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic        in_bus_busy,
  input  logic        in_start_sent,
  input  logic        in_addr_matched,
  input  logic        in_ack_error,
  input  logic        in_tx_empty,
  input  logic        in_rx_full,
  input  logic        in_byte_finished,
  input  logic        in_stop_seen,
  input  logic [7:0]  in_data_in,
  input  logic [7:0]  in_tx_byte,
  input  logic [15:0] in_remaining,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_issue_start,
  output logic        out_issue_stop,
  output logic        out_write_valid,
  output logic [7:0]  out_data_out,
  output logic        out_ack_on,
  output logic        out_ack_off,
  output logic        out_clear_ack_error,
  output logic        out_clear_stop_flag,
  output logic        out_read_valid,
  output logic [7:0]  out_read_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import i2cts_pkg::*;

  logic       role_r;
  logic [6:0] target_r;
  item_t      in_item, held_item;
  logic       held_valid, out_free, fire;
  result_t    core_res, out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r   <= ROLE_MASTER;
      target_r <= 7'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROLE:   role_r   <= cfg_data[0];
        CFG_TARGET: target_r <= cfg_data;
        default:    role_r   <= role_r;
      endcase
    end
  end

  always_comb begin
    in_item.command       = in_command;
    in_item.bus_busy      = in_bus_busy;
    in_item.start_sent    = in_start_sent;
    in_item.addr_matched  = in_addr_matched;
    in_item.ack_error     = in_ack_error;
    in_item.tx_empty      = in_tx_empty;
    in_item.rx_full       = in_rx_full;
    in_item.byte_finished = in_byte_finished;
    in_item.stop_seen     = in_stop_seen;
    in_item.data_in       = in_data_in;
    in_item.tx_byte       = in_tx_byte;
    in_item.remaining     = in_remaining;
  end

  assign fire = held_valid && out_free;

  i2cts_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (fire),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  i2cts_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .role           (role_r),
    .target_address (target_r),
    .item           (held_item),
    .res            (core_res)
  );

  i2cts_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res_in    (core_res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (out_res)
  );

  assign out_status          = out_res.status;
  assign out_issue_start     = out_res.issue_start;
  assign out_issue_stop      = out_res.issue_stop;
  assign out_write_valid     = out_res.write_valid;
  assign out_data_out        = out_res.data_out;
  assign out_ack_on          = out_res.ack_on;
  assign out_ack_off         = out_res.ack_off;
  assign out_clear_ack_error = out_res.clear_ack_error;
  assign out_clear_stop_flag = out_res.clear_stop_flag;
  assign out_read_valid      = out_res.read_valid;
  assign out_read_byte       = out_res.read_byte;
endmodule

[sv/i2cts_in_stage.sv]
// Input register stage: holds one poll word until the decision stage takes it.
module i2cts_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  i2cts_pkg::item_t in_item,
  input  logic           take,
  output logic           held_valid,
  output i2cts_pkg::item_t held_item
);
  import i2cts_pkg::*;

  logic  vld_r, vld_nxt;
  item_t item_r;
  logic  load;

  assign in_stall = vld_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign held_valid = vld_r;
  assign held_item  = item_r;
endmodule

[sv/i2cts_core.sv]
// Phase register and per-poll decision logic.
module i2cts_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic               role,
  input  logic [6:0]         target_address,
  input  i2cts_pkg::item_t   item,
  output i2cts_pkg::result_t res
);
  import i2cts_pkg::*;

  phase_t phase_r, phase_nxt;
  logic   rem_one, rem_two;

  assign rem_one = (item.remaining == 16'd1);
  assign rem_two = (item.remaining == 16'd2);

  always_comb begin
    res       = '0;
    res.status = ST_PENDING;
    phase_nxt = phase_r;
    if (item.remaining == 16'd0) begin
      res.status = ST_INVALID;
    end else if (role == ROLE_MASTER) begin
      case (phase_r)
        PH_IDLE: begin
          if (!item.bus_busy) begin
            res.issue_start = 1'b1;
            phase_nxt = PH_ADDR;
          end
        end
        PH_ADDR: begin
          if (item.start_sent) begin
            res.write_valid = 1'b1;
            res.data_out    = {target_address, item.command};
            res.ack_on      = (item.command == CMD_READ);
            res.ack_off     = (item.command == CMD_WRITE);
            phase_nxt = PH_ACK;
          end
        end
        PH_ACK: begin
          if (item.addr_matched) begin
            phase_nxt = PH_DATA;
          end else if (item.ack_error) begin
            res.clear_ack_error = 1'b1;
            res.status = ST_IOERR;
            phase_nxt = PH_IDLE;
          end
        end
        PH_DATA: begin
          if (item.command == CMD_READ) begin
            if (item.rx_full) begin
              res.ack_off    = rem_two;
              res.read_valid = 1'b1;
              res.read_byte  = item.data_in;
              if (rem_one) begin
                phase_nxt = PH_STOP;
              end else begin
                res.status = ST_MOVED;
              end
            end
          end else if (item.tx_empty) begin
            res.write_valid = 1'b1;
            res.data_out    = item.tx_byte;
            if (rem_one) begin
              phase_nxt = PH_STOP;
            end else begin
              res.status = ST_MOVED;
            end
          end
        end
        PH_STOP: begin
          if (item.byte_finished) begin
            res.issue_stop = 1'b1;
            res.status = ST_DONE;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          res.status = ST_IOERR;
        end
      endcase
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (item.addr_matched) begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          if (item.command == CMD_READ) begin
            if (item.rx_full) begin
              if (item.stop_seen) begin
                res.clear_stop_flag = 1'b1;
                res.status = ST_STOPRX;
                phase_nxt = PH_IDLE;
              end else begin
                res.read_valid = 1'b1;
                res.read_byte  = item.data_in;
                res.status = ST_MOVED;
              end
            end
          end else if (item.tx_empty) begin
            res.write_valid = 1'b1;
            res.data_out    = item.tx_byte;
            if (rem_one) begin
              phase_nxt = PH_STOP;
            end else begin
              res.status = ST_MOVED;
            end
          end
        end
        PH_STOP: begin
          if (item.command == CMD_READ) begin
            res.status = ST_IOERR;
          end else if (item.ack_error) begin
            res.clear_ack_error = 1'b1;
            res.status = ST_DONE;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          res.status = ST_IOERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (fire) begin
      phase_r <= phase_nxt;
    end
  end
endmodule

[sv/i2cts_out_stage.sv]
// Result register stage toward the output channel.
module i2cts_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  i2cts_pkg::result_t  res_in,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cts_pkg::result_t  res_out
);
  import i2cts_pkg::*;

  logic    vld_r, vld_nxt;
  result_t res_r;

  assign free = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = vld_r;
  assign res_out   = res_r;
endmodule
